/* rtl/aclw_pkg.sv */
// package for the fully associative write-back cache
// shared constants, operation codes and the controller-to-store command struct
package aclw_pkg;

  localparam int unsigned LinesDefault     = 4;
  localparam int unsigned WordsDefault     = 2;
  localparam int unsigned MemWordsDefault  = 1024;
  localparam logic [15:0] FillWord         = 16'hFFFF;

  localparam logic [1:0] KindRead    = 2'd0;
  localparam logic [1:0] KindWrite   = 2'd1;
  localparam logic [1:0] KindFlush   = 2'd2;
  localparam logic [1:0] KindPreload = 2'd3;

  typedef struct packed {
    logic we;
    logic re;
  } mem_cmd_t;

endpackage

/* rtl/aclw_backing_mem.sv */
// backing word memory with registered read data
// depends on aclw_pkg; it has no reset, the cache fills it with fill words in a clearing pass
module aclw_backing_mem #(
  parameter int unsigned MemWords = aclw_pkg::MemWordsDefault,
  parameter int unsigned AddrW    = $clog2(MemWords)
) (
  input  logic             clk_i,
  input  aclw_pkg::mem_cmd_t cmd_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [15:0]      wdata_i,
  output logic [15:0]      rdata_o
);

  logic [15:0] mem_q [MemWords];

  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (cmd_i.re) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

/* rtl/assoc_cache_lru_writeback.sv */
// Fully associative write-back, write-allocate cache with LRU replacement in
// front of an internal backing word memory. After reset a clearing pass fills
// backing memory with 0xFFFF while busy is high. An accepted request is looked
// up first; an illegal address or a preload then goes straight to the result,
// a write hit writes the line store and a read hit reads it and registers the
// word. A miss first writes a dirty victim back word by word, then fills the
// line word by word before the access. A flush walks every line and writes
// back each word of every dirty line through the single-port backing memory.
// Each result appears for one cycle with done_o, while busy is still high,
// and cannot be stalled.
// depends on aclw_pkg and aclw_backing_mem
module assoc_cache_lru_writeback #(
  parameter int unsigned LINES          = aclw_pkg::LinesDefault,
  parameter int unsigned WORDS_PER_LINE = aclw_pkg::WordsDefault,
  parameter int unsigned MEMORY_WORDS   = aclw_pkg::MemWordsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind_i,
  input  logic [15:0] address_i,
  input  logic [15:0] write_data_i,
  output logic        done_o,
  output logic [15:0] read_data_o,
  output logic        was_hit_o,
  output logic        illegal_address_o,
  output logic [31:0] hit_total_o,
  output logic [31:0] miss_total_o
);

  localparam int unsigned AW   = $clog2(MEMORY_WORDS);
  localparam int unsigned LW   = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int unsigned OW   = (WORDS_PER_LINE > 1) ? $clog2(WORDS_PER_LINE) : 1;
  localparam int unsigned CW   = $clog2(LINES * WORDS_PER_LINE);
  localparam int unsigned TW   = 17;
  localparam int unsigned NW   = LINES * WORDS_PER_LINE;
  localparam logic [LW-1:0] TopRank = LW'(LINES - 1);

  localparam logic [3:0] StClear = 4'd0;
  localparam logic [3:0] StIdle  = 4'd1;
  localparam logic [3:0] StLook  = 4'd2;
  localparam logic [3:0] StWb    = 4'd3;
  localparam logic [3:0] StFillR = 4'd4;
  localparam logic [3:0] StFillW = 4'd5;
  localparam logic [3:0] StAcc   = 4'd6;
  localparam logic [3:0] StAccW  = 4'd7;
  localparam logic [3:0] StFlush = 4'd8;
  localparam logic [3:0] StFlWb  = 4'd9;
  localparam logic [3:0] StDone  = 4'd10;

  logic [3:0]        state_q, state_d;
  logic [AW:0]       clr_q, clr_d;
  logic [LINES-1:0]  valid_q, valid_d, dirty_q, dirty_d;
  logic [TW-1:0]     tag_q [LINES];
  logic [LW-1:0]     rank_q [LINES];
  logic [LINES-1:0]  written_q, written_d;
  logic [NW-1:0]     wvalid_q, wvalid_d;
  logic [1:0]        kind_q;
  logic [15:0]       addr_q, wd_q;
  logic [LW-1:0]     line_q, line_d;
  logic [OW:0]       wcnt_q, wcnt_d;
  logic              hit_q, hit_d, ill_q, ill_d;
  logic [15:0]       rd_q, rd_d;
  logic [31:0]       hits_q, hits_d, misses_q, misses_d;
  logic              touch_en;

  // line data store
  logic [15:0]       lw_mem [NW];
  logic [15:0]       lw_rdata;
  logic              lw_we, lw_re;
  logic [CW-1:0]     lw_waddr, lw_raddr;
  logic [15:0]       lw_wdata;

  aclw_pkg::mem_cmd_t bm_cmd;
  logic [AW-1:0]     bm_addr;
  logic [15:0]       bm_wdata, bm_rdata;

  aclw_backing_mem #(.MemWords(MEMORY_WORDS), .AddrW(AW)) u_mem (
    .clk_i  (clk_i),
    .cmd_i  (bm_cmd),
    .addr_i (bm_addr),
    .wdata_i(bm_wdata),
    .rdata_o(bm_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (lw_we) begin
      lw_mem[lw_waddr] <= lw_wdata;
    end
    if (lw_re) begin
      lw_rdata <= lw_mem[lw_raddr];
    end
  end

  logic [TW-1:0] req_tag;
  logic [OW-1:0] req_off;
  logic          hit_any;
  logic [LW-1:0] hit_line, vict;
  logic [TW-1:0] vic_base_tag;
  logic [TW+OW:0] wb_addr_full, fill_addr_full;
  logic [CW-1:0] cur_word;
  logic          wb_word_ok;

  always_comb begin
    req_tag = TW'({1'b0, addr_q} / WORDS_PER_LINE);
    req_off = OW'({1'b0, addr_q} % WORDS_PER_LINE);
    hit_any = 1'b0;
    hit_line = '0;
    for (int i = LINES - 1; i >= 0; i--) begin
      if (valid_q[i] && tag_q[i] == req_tag) begin
        hit_any = 1'b1;
        hit_line = LW'(i);
      end
    end
    vict = '0;
    for (int i = LINES - 1; i >= 1; i--) begin
      if (rank_q[i] < rank_q[vict]) begin
        vict = LW'(i);
      end
    end
    if (rank_q[0] <= rank_q[vict]) begin
      vict = '0;
    end
    for (int i = LINES - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        vict = LW'(i);
      end
    end
    vic_base_tag = tag_q[line_q];
    cur_word = CW'(32'(line_q) * WORDS_PER_LINE + 32'(wcnt_q[OW-1:0]));
    wb_addr_full = (TW+OW+1)'(vic_base_tag) * (TW+OW+1)'(WORDS_PER_LINE)
                   + (TW+OW+1)'(wcnt_q);
    fill_addr_full = (TW+OW+1)'(req_tag) * (TW+OW+1)'(WORDS_PER_LINE)
                     + (TW+OW+1)'(wcnt_q);
    wb_word_ok = wb_addr_full < (TW+OW+1)'(MEMORY_WORDS);
  end

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    valid_d   = valid_q;
    dirty_d   = dirty_q;
    written_d = written_q;
    wvalid_d  = wvalid_q;
    line_d    = line_q;
    wcnt_d    = wcnt_q;
    hit_d     = hit_q;
    ill_d     = ill_q;
    rd_d      = rd_q;
    hits_d    = hits_q;
    misses_d  = misses_q;
    touch_en  = 1'b0;
    bm_cmd    = '0;
    bm_addr   = addr_q[AW-1:0];
    bm_wdata  = wd_q;
    lw_we     = 1'b0;
    lw_re     = 1'b0;
    lw_waddr  = cur_word;
    lw_raddr  = cur_word;
    lw_wdata  = bm_rdata;
    unique case (state_q)
      StClear: begin
        bm_cmd.we = 1'b1;
        bm_addr   = clr_q[AW-1:0];
        bm_wdata  = aclw_pkg::FillWord;
        clr_d     = clr_q + 1'b1;
        if (clr_q == (AW+1)'(MEMORY_WORDS - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (start) begin
          state_d = StLook;
        end
      end
      StLook: begin
        hit_d = 1'b0;
        ill_d = 1'b0;
        rd_d  = '0;
        wcnt_d = '0;
        if (kind_q == aclw_pkg::KindFlush) begin
          line_d  = '0;
          state_d = StFlush;
        end else if ({1'b0, addr_q} >= 17'(MEMORY_WORDS)) begin
          ill_d   = 1'b1;
          state_d = StDone;
        end else if (kind_q == aclw_pkg::KindPreload) begin
          bm_cmd.we = 1'b1;
          state_d   = StDone;
        end else if (hit_any) begin
          hit_d   = 1'b1;
          line_d  = hit_line;
          if (hits_q != '1) hits_d = hits_q + 1'b1;
          state_d = StAcc;
        end else begin
          line_d  = vict;
          if (misses_q != '1) misses_d = misses_q + 1'b1;
          state_d = (valid_q[vict] && dirty_q[vict]) ? StWb : StFillR;
        end
      end
      StWb: begin
        // per word, a data store read here then the backing write in StFillW
        lw_re = 1'b1;
        state_d = StFillW;
        hit_d = 1'b0;
      end
      StFillR: begin
        bm_cmd.re = 1'b1;
        bm_addr   = fill_addr_full[AW-1:0];
        state_d   = StFillW;
      end
      StFillW: begin
        if (dirty_q[line_q]) begin
          bm_cmd.we = wb_word_ok;
          bm_addr   = wb_addr_full[AW-1:0];
          bm_wdata  = (wvalid_q[cur_word] && written_q[line_q]) ? lw_rdata
                                                                : aclw_pkg::FillWord;
          if (wcnt_q == (OW+1)'(WORDS_PER_LINE - 1)) begin
            wcnt_d = '0;
            dirty_d[line_q] = 1'b0;
            state_d = (kind_q == aclw_pkg::KindFlush) ? StFlush : StFillR;
            if (kind_q == aclw_pkg::KindFlush) line_d = line_q + 1'b1;
          end else begin
            wcnt_d  = wcnt_q + 1'b1;
            state_d = StWb;
          end
        end else begin
          lw_we    = 1'b1;
          lw_wdata = (fill_addr_full < (TW+OW+1)'(MEMORY_WORDS)) ? bm_rdata
                                                                 : aclw_pkg::FillWord;
          wvalid_d[cur_word] = 1'b1;
          if (wcnt_q == (OW+1)'(WORDS_PER_LINE - 1)) begin
            wcnt_d = '0;
            valid_d[line_q] = 1'b1;
            written_d[line_q] = 1'b1;
            state_d = StAcc;
          end else begin
            wcnt_d  = wcnt_q + 1'b1;
            state_d = StFillR;
          end
        end
      end
      StAcc: begin
        touch_en = 1'b1;
        wcnt_d   = (OW+1)'(req_off);
        if (kind_q == aclw_pkg::KindRead) begin
          lw_re    = 1'b1;
          lw_raddr = CW'(32'(line_q) * WORDS_PER_LINE + 32'(req_off));
          state_d  = StAccW;
        end else begin
          lw_we    = 1'b1;
          lw_waddr = CW'(32'(line_q) * WORDS_PER_LINE + 32'(req_off));
          lw_wdata = wd_q;
          wvalid_d[lw_waddr] = 1'b1;
          dirty_d[line_q]    = 1'b1;
          written_d[line_q]  = 1'b1;
          state_d  = StDone;
        end
      end
      StAccW: begin
        rd_d    = wvalid_q[CW'(32'(line_q) * WORDS_PER_LINE + 32'(req_off))] ? lw_rdata
                                                                   : aclw_pkg::FillWord;
        state_d = StDone;
      end
      StFlush: begin
        if (dirty_q[line_q]) begin
          state_d = StWb;
        end else if (line_q == TopRank) begin
          state_d = StDone;
        end else begin
          line_d = line_q + 1'b1;
        end
      end
      StDone: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
    if (state_q == StFillW && dirty_q[line_q] && kind_q == aclw_pkg::KindFlush
        && wcnt_q == (OW+1)'(WORDS_PER_LINE - 1) && line_q == TopRank) begin
      state_d = StDone;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StClear;
      clr_q     <= '0;
      valid_q   <= '0;
      dirty_q   <= '0;
      written_q <= '0;
      wvalid_q  <= '0;
      line_q    <= '0;
      wcnt_q    <= '0;
      hit_q     <= 1'b0;
      ill_q     <= 1'b0;
      rd_q      <= '0;
      hits_q    <= '0;
      misses_q  <= '0;
      for (int i = 0; i < LINES; i++) rank_q[i] <= '0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      valid_q   <= valid_d;
      dirty_q   <= dirty_d;
      written_q <= written_d;
      wvalid_q  <= wvalid_d;
      line_q    <= line_d;
      wcnt_q    <= wcnt_d;
      hit_q     <= hit_d;
      ill_q     <= ill_d;
      rd_q      <= rd_d;
      hits_q    <= hits_d;
      misses_q  <= misses_d;
      if (touch_en) begin
        for (int i = 0; i < LINES; i++) begin
          if (LW'(i) == line_q) rank_q[i] <= TopRank;
          else if (rank_q[i] > rank_q[line_q]) rank_q[i] <= rank_q[i] - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start) begin
      kind_q <= kind_i;
      addr_q <= address_i;
      wd_q   <= write_data_i;
    end
    if (state_q == StFillW && !dirty_q[line_q] && wcnt_q == (OW+1)'(WORDS_PER_LINE - 1)) begin
      tag_q[line_q] <= req_tag;
    end
  end

  assign busy              = (state_q != StIdle);
  assign done_o            = (state_q == StDone);
  assign read_data_o       = rd_q;
  assign was_hit_o         = hit_q;
  assign illegal_address_o = ill_q;
  assign hit_total_o       = hits_q;
  assign miss_total_o      = misses_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(was_hit_o && illegal_address_o))
    else $error("hit on illegal address");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle && state_q != StClear && $past(state_q) != StIdle)
      |-> $stable(addr_q))
    else $error("request changed in flight");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(dirty_q & ~valid_q) && ((dirty_q & ~valid_q) == '0))
    else $error("dirty line not valid");

endmodule
